>>> design/brrq_pkg.sv
package brrq_pkg;

  typedef logic [7:0] byte_t;

  // item kinds
  typedef enum logic [2:0] {
    KIND_BEGIN   = 3'd0,
    KIND_BYTE    = 3'd1,
    KIND_RELEASE = 3'd2,
    KIND_COMPARE = 3'd3,
    KIND_READ    = 3'd4
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_ROOM     = 2'd1,
    ST_BAD_RELEASE = 2'd2,
    ST_SEQ_ERROR   = 2'd3
  } status_t;

  // record terminator byte
  localparam byte_t TERMINATOR = 8'h00;

endpackage

>>> design/brrq_store.sv
// single-port byte store, registered read data
module brrq_store #(
  parameter int ADDR_W = 12
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   addr,
  input  brrq_pkg::byte_t     wdata,
  output brrq_pkg::byte_t     rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  brrq_pkg::byte_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> design/byte_ring_record_queue.sv
// byte ring record queue: one transaction in flight at a time, one result per transaction
// begin, release, non-final record byte and bad kinds: result registered in the cycle after accept, busy stays low
// final record byte: data write, then terminator write from S_TERM on the single store port
// compare and read: store read issued on accept, registered read data used in S_READ to form the result
// final record bytes, compares and reads hold busy high in S_TERM or S_READ, so no new transaction is taken there
// synchronous reset clears pointers, counters and control; the byte store itself is not cleared
module byte_ring_record_queue #(
  parameter int STORE_LOG2 = 12,
  parameter int POS_WIDTH  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // command side
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            kind,
  input  logic [11:0]           length,
  input  logic [31:0]           position,
  input  logic [7:0]            data_byte,
  input  logic                  compare_last,
  // result side, the receiver cannot stall: strobe marks each result for exactly one cycle
  output logic                  strobe,
  output logic [1:0]            status,
  output logic [31:0]           record_start,
  output logic [7:0]            byte_out,
  output logic                  equal,
  output logic                  done_res,
  output logic [STORE_LOG2:0]   fill,
  output logic [31:0]           next_free
);

  localparam int STORE_SIZE = 1 << STORE_LOG2;
  localparam int CW         = STORE_LOG2 + 1;   // holds 0 .. STORE_SIZE (+1 for compare count)

  typedef enum logic [1:0] {
    S_IDLE,
    S_TERM,   // final record byte written, terminator write pending
    S_READ    // store read issued, data arrives this cycle
  } state_t;

  state_t state, state_next;

  // ring pointers, absolute positions that wrap at POS_WIDTH bits
  logic [POS_WIDTH-1:0]  free_head, free_head_next;
  logic [POS_WIDTH-1:0]  used_head, used_head_next;
  logic [CW-1:0]         used_count, used_count_next;

  // open record tracking
  logic                  write_open, write_open_next;
  logic [11:0]           write_remaining, write_remaining_next;
  logic [POS_WIDTH-1:0]  write_cursor, write_cursor_next;

  // compare run accumulation
  logic                  match_so_far, match_so_far_next;
  logic [CW-1:0]         compare_count, compare_count_next;

  // operands held across the store read
  brrq_pkg::byte_t       cmp_byte, cmp_byte_next;
  logic                  cmp_last, cmp_last_next;
  logic                  is_read, is_read_next;

  // registered result
  logic                  strobe_next;
  logic [1:0]            status_next;
  logic [31:0]           record_start_next;
  logic [7:0]            byte_out_next;
  logic                  equal_next;
  logic                  done_res_next;
  logic [STORE_LOG2:0]   fill_next;
  logic [31:0]           next_free_next;

  // store port
  logic                  mem_we;
  logic [STORE_LOG2-1:0] mem_addr;
  brrq_pkg::byte_t       mem_wdata;
  brrq_pkg::byte_t       mem_rdata;

  // helpers
  logic [POS_WIDTH-1:0]  pos_in;
  logic [12:0]           total;
  logic [POS_WIDTH-1:0]  cursor_inc;
  logic [11:0]           remaining_dec;
  logic                  match_new;
  logic [CW-1:0]         count_new;

  brrq_store #(
    .ADDR_W (STORE_LOG2)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    pos_in        = POS_WIDTH'(position);
    total         = {1'b0, length} + 13'd1;
    cursor_inc    = write_cursor + POS_WIDTH'(1);
    remaining_dec = write_remaining - 12'd1;
    match_new     = match_so_far && (mem_rdata == cmp_byte);
    count_new     = (32'(compare_count) <= 32'(STORE_SIZE)) ?
                    (compare_count + CW'(1)) : compare_count;

    state_next           = state;
    free_head_next       = free_head;
    used_head_next       = used_head;
    used_count_next      = used_count;
    write_open_next      = write_open;
    write_remaining_next = write_remaining;
    write_cursor_next    = write_cursor;
    match_so_far_next    = match_so_far;
    compare_count_next   = compare_count;
    cmp_byte_next        = cmp_byte;
    cmp_last_next        = cmp_last;
    is_read_next         = is_read;

    strobe_next          = 1'b0;
    status_next          = status;
    record_start_next    = record_start;
    byte_out_next        = byte_out;
    equal_next           = equal;
    done_res_next        = done_res;

    mem_we    = 1'b0;
    mem_addr  = STORE_LOG2'(pos_in);
    mem_wdata = data_byte;

    case (state)
      S_IDLE: begin
        if (start) begin
          strobe_next       = 1'b1;
          status_next       = brrq_pkg::ST_OK;
          record_start_next = '0;
          byte_out_next     = '0;
          equal_next        = 1'b0;
          done_res_next     = 1'b0;
          case (kind)
            brrq_pkg::KIND_BEGIN: begin
              if (write_open) begin
                status_next = brrq_pkg::ST_SEQ_ERROR;
              end else if (32'(total) > 32'(STORE_SIZE) - 32'(used_count)) begin
                status_next = brrq_pkg::ST_NO_ROOM;
              end else begin
                record_start_next = 32'(free_head);
                if (length == '0) begin
                  // empty record: terminator only, commits right away
                  mem_we          = 1'b1;
                  mem_addr        = STORE_LOG2'(free_head);
                  mem_wdata       = brrq_pkg::TERMINATOR;
                  free_head_next  = free_head + POS_WIDTH'(1);
                  used_count_next = used_count + CW'(1);
                  done_res_next   = 1'b1;
                end else begin
                  write_open_next      = 1'b1;
                  write_remaining_next = length;
                  write_cursor_next    = free_head;
                end
              end
            end
            brrq_pkg::KIND_BYTE: begin
              if (!write_open) begin
                status_next = brrq_pkg::ST_SEQ_ERROR;
              end else begin
                mem_we               = 1'b1;
                mem_addr             = STORE_LOG2'(write_cursor);
                mem_wdata            = data_byte;
                write_cursor_next    = cursor_inc;
                write_remaining_next = remaining_dec;
                if (remaining_dec == '0) begin
                  // last byte: commit now, terminator goes in next cycle
                  used_count_next = used_count +
                                    CW'(cursor_inc + POS_WIDTH'(1) - free_head);
                  free_head_next  = cursor_inc + POS_WIDTH'(1);
                  write_open_next = 1'b0;
                  done_res_next   = 1'b1;
                  strobe_next     = 1'b0;
                  state_next      = S_TERM;
                end
              end
            end
            brrq_pkg::KIND_RELEASE: begin
              if (pos_in != used_head || 32'(used_count) < 32'(total)) begin
                status_next = brrq_pkg::ST_BAD_RELEASE;
              end else begin
                used_head_next  = used_head + POS_WIDTH'(total);
                used_count_next = used_count - CW'(total);
              end
            end
            brrq_pkg::KIND_COMPARE, brrq_pkg::KIND_READ: begin
              // address already on the store port; data is back next cycle
              cmp_byte_next = data_byte;
              cmp_last_next = compare_last;
              is_read_next  = (kind == brrq_pkg::KIND_READ);
              strobe_next   = 1'b0;
              state_next    = S_READ;
            end
            default: begin
              status_next = brrq_pkg::ST_SEQ_ERROR;
            end
          endcase
        end
      end
      S_TERM: begin
        mem_we      = 1'b1;
        mem_addr    = STORE_LOG2'(write_cursor);
        mem_wdata   = brrq_pkg::TERMINATOR;
        strobe_next = 1'b1;
        state_next  = S_IDLE;
      end
      S_READ: begin
        if (is_read) begin
          byte_out_next = mem_rdata;
        end else if (cmp_last) begin
          equal_next         = match_new && (32'(count_new) <= 32'(STORE_SIZE));
          done_res_next      = 1'b1;
          match_so_far_next  = 1'b1;
          compare_count_next = '0;
        end else begin
          match_so_far_next  = match_new;
          compare_count_next = count_new;
        end
        strobe_next = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // occupancy and free head as they stand after the transaction
    fill_next      = used_count_next;
    next_free_next = 32'(free_head_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      free_head       <= '0;
      used_head       <= '0;
      used_count      <= '0;
      write_open      <= 1'b0;
      write_remaining <= '0;
      write_cursor    <= '0;
      match_so_far    <= 1'b1;
      compare_count   <= '0;
      strobe          <= 1'b0;
    end else begin
      state           <= state_next;
      free_head       <= free_head_next;
      used_head       <= used_head_next;
      used_count      <= used_count_next;
      write_open      <= write_open_next;
      write_remaining <= write_remaining_next;
      write_cursor    <= write_cursor_next;
      match_so_far    <= match_so_far_next;
      compare_count   <= compare_count_next;
      strobe          <= strobe_next;
    end
    // payload, no reset needed
    cmp_byte     <= cmp_byte_next;
    cmp_last     <= cmp_last_next;
    is_read      <= is_read_next;
    status       <= status_next;
    record_start <= record_start_next;
    byte_out     <= byte_out_next;
    equal        <= equal_next;
    done_res     <= done_res_next;
    fill         <= fill_next;
    next_free    <= next_free_next;
  end

endmodule

>>> sim/tb.sv
module tb;

  localparam int STORE_LOG2 = 12;
  localparam int RING_SIZE  = 1 << STORE_LOG2;
  // two copies of the ring state: one steers stimulus generation, one predicts results
  localparam int PLAN = 0;
  localparam int LIVE = 1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] length;
    logic [31:0] position;
    logic [7:0]  data_byte;
    logic        compare_last;
  } ring_cmd_t;

  typedef struct packed {
    brrq_pkg::status_t status;
    logic [31:0] record_start;
    logic [7:0]  byte_out;
    logic        equal;
    logic        done_res;
    logic [12:0] fill;
    logic [31:0] next_free;
  } ring_resp_t;

  typedef struct packed {
    ring_cmd_t cmd;
    logic [6:0] idle_pct;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] kind = '0;
  logic [11:0] length = '0;
  logic [31:0] position = '0;
  logic [7:0] data_byte = '0;
  logic compare_last = 1'b0;
  logic strobe;
  logic [1:0] status;
  logic [31:0] record_start;
  logic [7:0] byte_out;
  logic equal;
  logic done_res;
  logic [STORE_LOG2:0] fill;
  logic [31:0] next_free;

  // ring state copies
  brrq_pkg::byte_t ring_mem [2][RING_SIZE];
  bit ring_written [2][RING_SIZE];
  logic [31:0] head_free [2];
  logic [31:0] head_used [2];
  logic [31:0] cursor_wr [2];
  logic [12:0] count_used [2];
  logic open_wr [2];
  logic [11:0] remain_wr [2];
  logic match_acc [2];
  int unsigned cmp_len [2];

  pending_t pending[$];
  ring_resp_t expected_resp[$];
  int rec_lens[$];
  int open_len;
  int unsigned gen_idle_pct;
  int mismatches = 0;
  pending_t next_item;
  ring_cmd_t live_cmd;
  ring_resp_t want_resp;

  always #1 clk = ~clk;

  byte_ring_record_queue i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .length       (length),
    .position     (position),
    .data_byte    (data_byte),
    .compare_last (compare_last),
    .strobe       (strobe),
    .status       (status),
    .record_start (record_start),
    .byte_out     (byte_out),
    .equal        (equal),
    .done_res     (done_res),
    .fill         (fill),
    .next_free    (next_free)
  );

  function automatic logic [STORE_LOG2-1:0] slot_of(logic [31:0] p);
    return p[STORE_LOG2-1:0];
  endfunction

  function automatic void ring_clear(int c);
    head_free[c] = '0;
    head_used[c] = '0;
    cursor_wr[c] = '0;
    count_used[c] = '0;
    open_wr[c] = 1'b0;
    remain_wr[c] = '0;
    match_acc[c] = 1'b1;
    cmp_len[c] = 0;
    for (int i = 0; i < RING_SIZE; i++) ring_written[c][i] = 1'b0;
  endfunction

  // applies one transaction to ring copy c and returns its result
  function automatic ring_resp_t ring_apply(int c, ring_cmd_t cmd);
    ring_resp_t r;
    logic [12:0] total;
    r = '0;
    total = {1'b0, cmd.length} + 13'd1;
    case (cmd.kind)
      brrq_pkg::KIND_BEGIN: begin
        if (open_wr[c]) begin
          r.status = brrq_pkg::ST_SEQ_ERROR;
        end else if (total > RING_SIZE - count_used[c]) begin
          r.status = brrq_pkg::ST_NO_ROOM;
        end else begin
          r.record_start = head_free[c];
          if (cmd.length == 0) begin
            // empty record: terminator only, commits at once
            ring_mem[c][slot_of(head_free[c])] = brrq_pkg::TERMINATOR;
            ring_written[c][slot_of(head_free[c])] = 1'b1;
            head_free[c] = head_free[c] + 32'd1;
            count_used[c] = count_used[c] + 13'd1;
            r.done_res = 1'b1;
          end else begin
            open_wr[c] = 1'b1;
            remain_wr[c] = cmd.length;
            cursor_wr[c] = head_free[c];
          end
        end
      end
      brrq_pkg::KIND_BYTE: begin
        if (!open_wr[c]) begin
          r.status = brrq_pkg::ST_SEQ_ERROR;
        end else begin
          ring_mem[c][slot_of(cursor_wr[c])] = cmd.data_byte;
          ring_written[c][slot_of(cursor_wr[c])] = 1'b1;
          cursor_wr[c] = cursor_wr[c] + 32'd1;
          remain_wr[c] = remain_wr[c] - 12'd1;
          if (remain_wr[c] == 0) begin
            ring_mem[c][slot_of(cursor_wr[c])] = brrq_pkg::TERMINATOR;
            ring_written[c][slot_of(cursor_wr[c])] = 1'b1;
            count_used[c] = count_used[c] + 13'(cursor_wr[c] + 32'd1 - head_free[c]);
            head_free[c] = cursor_wr[c] + 32'd1;
            open_wr[c] = 1'b0;
            r.done_res = 1'b1;
          end
        end
      end
      brrq_pkg::KIND_RELEASE: begin
        if (cmd.position != head_used[c] || count_used[c] < total) begin
          r.status = brrq_pkg::ST_BAD_RELEASE;
        end else begin
          head_used[c] = head_used[c] + {19'd0, total};
          count_used[c] = count_used[c] - total;
        end
      end
      brrq_pkg::KIND_COMPARE: begin
        if (ring_mem[c][slot_of(cmd.position)] != cmd.data_byte) match_acc[c] = 1'b0;
        if (cmp_len[c] <= RING_SIZE) cmp_len[c]++;
        if (cmd.compare_last) begin
          // a run longer than the store never reports equal
          r.equal = match_acc[c] && (cmp_len[c] <= RING_SIZE);
          r.done_res = 1'b1;
          match_acc[c] = 1'b1;
          cmp_len[c] = 0;
        end
      end
      brrq_pkg::KIND_READ: begin
        r.byte_out = ring_mem[c][slot_of(cmd.position)];
      end
      default: begin
        r.status = brrq_pkg::ST_SEQ_ERROR;
      end
    endcase
    r.fill = count_used[c];
    r.next_free = head_free[c];
    return r;
  endfunction

  function automatic ring_cmd_t rand_cmd(logic [2:0] k);
    ring_cmd_t cmd;
    cmd.kind = k;
    cmd.length = 12'($urandom);
    cmd.position = $urandom;
    cmd.data_byte = 8'($urandom);
    cmd.compare_last = 1'($urandom);
    return cmd;
  endfunction

  // queue one transaction and keep the planning copy and record list in step
  task automatic plan_push(ring_cmd_t cmd);
    ring_resp_t r;
    pending_t item;
    r = ring_apply(PLAN, cmd);
    if (cmd.kind == brrq_pkg::KIND_BEGIN && r.status == brrq_pkg::ST_OK) begin
      if (cmd.length == 0) rec_lens.push_back(0);
      else open_len = cmd.length;
    end
    if (cmd.kind == brrq_pkg::KIND_BYTE && r.done_res) rec_lens.push_back(open_len);
    if (cmd.kind == brrq_pkg::KIND_RELEASE && r.status == brrq_pkg::ST_OK)
      void'(rec_lens.pop_front());
    item.cmd = cmd;
    item.idle_pct = 7'(gen_idle_pct);
    pending.push_back(item);
  endtask

  task automatic begin_record(logic [11:0] len);
    ring_cmd_t cmd;
    cmd = rand_cmd(brrq_pkg::KIND_BEGIN);
    cmd.length = len;
    plan_push(cmd);
  endtask

  task automatic put_byte(logic [7:0] d);
    ring_cmd_t cmd;
    cmd = rand_cmd(brrq_pkg::KIND_BYTE);
    cmd.data_byte = d;
    plan_push(cmd);
  endtask

  task automatic release_at(logic [31:0] pos, logic [11:0] len);
    ring_cmd_t cmd;
    cmd = rand_cmd(brrq_pkg::KIND_RELEASE);
    cmd.position = pos;
    cmd.length = len;
    plan_push(cmd);
  endtask

  task automatic release_oldest();
    release_at(head_used[PLAN], 12'(rec_lens[0]));
  endtask

  task automatic read_byte(logic [31:0] pos);
    ring_cmd_t cmd;
    cmd = rand_cmd(brrq_pkg::KIND_READ);
    cmd.position = pos;
    plan_push(cmd);
  endtask

  // compare run over consecutive written bytes, the byte at index flip altered (none if flip is outside the run)
  task automatic compare_run(logic [31:0] pos, int n, int flip);
    ring_cmd_t cmd;
    int run;
    run = 0;
    while (run < n && ring_written[PLAN][slot_of(pos + run)]) run++;
    for (int i = 0; i < run; i++) begin
      cmd = rand_cmd(brrq_pkg::KIND_COMPARE);
      cmd.position = pos + i;
      cmd.data_byte = ring_mem[PLAN][slot_of(pos + i)];
      if (i == flip) cmd.data_byte = cmd.data_byte ^ 8'(1 << $urandom_range(7));
      cmd.compare_last = (i == run - 1);
      plan_push(cmd);
    end
  endtask

  // random position whose slot holds written data, upper bits random
  task automatic pick_written(output bit ok, output logic [31:0] pos);
    logic [31:0] base;
    base = $urandom;
    ok = 1'b0;
    pos = '0;
    for (int i = 0; i < RING_SIZE && !ok; i++) begin
      if (ring_written[PLAN][slot_of(base + i)]) begin
        ok = 1'b1;
        pos = base + i;
      end
    end
  endtask

  function automatic logic [11:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 12'd0;
    if (r < 85) return 12'($urandom_range(1, 20));
    return 12'($urandom_range(21, 200));
  endfunction

  // malformed or out-of-order transactions, plus some well-formed compares, reads and releases
  task automatic noise_item();
    ring_cmd_t cmd;
    logic [31:0] pos;
    bit ok;
    case ($urandom_range(6))
      0: begin
        if (open_wr[PLAN]) begin
          begin_record(12'($urandom));
        end else if (count_used[PLAN] != 0) begin
          begin_record(12'($urandom_range(RING_SIZE - count_used[PLAN], RING_SIZE - 1)));
        end else begin
          put_byte(8'($urandom));
        end
      end
      1: release_at(head_used[PLAN] ^ ($urandom | (32'd1 << $urandom_range(31))),
                    12'($urandom));
      2: begin
        if (count_used[PLAN] < RING_SIZE)
          release_at(head_used[PLAN], 12'($urandom_range(count_used[PLAN], RING_SIZE - 1)));
      end
      3: put_byte(8'($urandom));
      4: plan_push(rand_cmd(3'($urandom_range(5, 7))));
      5: begin
        pick_written(ok, pos);
        if (ok) begin
          cmd = rand_cmd($urandom_range(1) ? brrq_pkg::KIND_COMPARE : brrq_pkg::KIND_READ);
          cmd.position = pos;
          plan_push(cmd);
        end else begin
          plan_push(rand_cmd(3'($urandom_range(5, 7))));
        end
      end
      default: begin
        if (rec_lens.size() != 0) release_oldest();
        else put_byte(8'($urandom));
      end
    endcase
  endtask

  // mostly well-formed record traffic with compares, reads and some noise
  task automatic random_item();
    int unsigned pick;
    int n;
    logic [31:0] pos;
    bit ok;
    pick = $urandom_range(99);
    if (open_wr[PLAN] && pick < 85) begin
      put_byte(8'($urandom));
    end else if (open_wr[PLAN] || pick >= 80) begin
      noise_item();
    end else if (pick < 30 || (pick < 45 && rec_lens.size() < 3)) begin
      begin_record(pick_length());
    end else if (pick < 45) begin
      release_oldest();
    end else begin
      pick_written(ok, pos);
      n = $urandom_range(1, 12);
      if (!ok) begin_record(pick_length());
      else if (pick < 62) compare_run(pos, n, $urandom_range(1) ? $urandom_range(n - 1) : -1);
      else read_byte(pos);
    end
  endtask

  task automatic build_stimulus();
    logic [31:0] rec_pos;
    gen_idle_pct = 21;
    // directed: sequence errors and releases on an empty ring
    put_byte(8'h5A);
    release_at(32'd0, 12'd0);
    plan_push(rand_cmd(3'd5));
    plan_push(rand_cmd(3'd6));
    plan_push(rand_cmd(3'd7));
    // empty record, then a short one with extreme bytes
    begin_record(12'd0);
    rec_pos = head_free[PLAN];
    begin_record(12'd3);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(8'hA5);
    // begin while open, release while open
    begin_record(12'd2);
    begin_record(12'd7);
    release_oldest();
    put_byte(8'h01);
    put_byte(8'h80);
    begin_record(12'hFFF);
    compare_run(rec_pos, 3, -1);
    compare_run(rec_pos, 3, 1);
    read_byte({20'hFFFFF, rec_pos[11:0]});
    release_at(head_used[PLAN] ^ 32'h8000_0000, 12'(rec_lens[0]));
    release_at(head_used[PLAN], 12'hFFF);
    release_oldest();
    read_byte(rec_pos + 32'd3);

    repeat (530) random_item();
    gen_idle_pct = 85;
    repeat (530) random_item();
    gen_idle_pct = 0;
    repeat (540) random_item();
  endtask

  // driver: hold each transaction until accepted, predict at acceptance
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_resp.push_back(ring_apply(LIVE, live_cmd));
      if (!start || !busy) begin
        if (pending.size() != 0 && $urandom_range(99) >= pending[0].idle_pct) begin
          next_item = pending.pop_front();
          live_cmd = next_item.cmd;
          kind <= live_cmd.kind;
          length <= live_cmd.length;
          position <= live_cmd.position;
          data_byte <= live_cmd.data_byte;
          compare_last <= live_cmd.compare_last;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // monitor: every strobe carries one result, checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_resp.size() == 0) begin
        $error("result strobe with no transaction outstanding");
        mismatches++;
      end else begin
        want_resp = expected_resp.pop_front();
        check_field("status", 32'(want_resp.status), 32'(status));
        check_field("record_start", want_resp.record_start, record_start);
        check_field("byte_out", 32'(want_resp.byte_out), 32'(byte_out));
        check_field("equal", 32'(want_resp.equal), 32'(equal));
        check_field("done_res", 32'(want_resp.done_res), 32'(done_res));
        check_field("fill", 32'(want_resp.fill), 32'(fill));
        check_field("next_free", want_resp.next_free, next_free);
      end
    end
  end

  initial begin
    ring_clear(PLAN);
    ring_clear(LIVE);
    build_stimulus();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (pending.size() != 0 || start || expected_resp.size() != 0) @(posedge clk);
    // drain window for any late strobe
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> filelist.f
design/brrq_pkg.sv
design/brrq_store.sv
design/byte_ring_record_queue.sv
sim/tb.sv
